// ===== src/sds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared widths, types, register indexes, reset values and the sweep
// segment order used by the scheduler core and its arithmetic unit.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W        = $clog2(MAX_REQUESTS);
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int CYL_W        = 16;
	localparam int TOT_W        = 17;
	localparam int CFG_IDX_W    = 2;

	typedef logic [CYL_W-1:0] cyl_t;
	typedef logic [TOT_W-1:0] total_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} alu_flags_t;

	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_DIRECTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CYLINDER  = 2'd2;

	localparam cyl_t RESET_START_HEAD     = 16'd125;
	localparam logic RESET_SCAN_DIRECTION = 1'b1;
	localparam cyl_t RESET_LAST_CYLINDER  = 16'd199;

	typedef logic [2:0] seg_kind_t;
	typedef logic [2:0] seg_ph_t;

	localparam seg_kind_t K_UPA  = 3'd0;
	localparam seg_kind_t K_UPB  = 3'd1;
	localparam seg_kind_t K_DOWN = 3'd2;
	localparam seg_kind_t K_END  = 3'd3;
	localparam seg_kind_t K_DONE = 3'd4;

	// Order of sweep segments for each direction.
	function automatic seg_kind_t seg_kind(input logic dir, input seg_ph_t ph);
		seg_kind_t k;
		k = K_DONE;
		if (dir) begin
			unique case (ph)
				3'd0:    k = K_UPA;
				3'd1:    k = K_END;
				3'd2:    k = K_DOWN;
				default: k = K_DONE;
			endcase
		end else begin
			unique case (ph)
				3'd0:    k = K_UPA;
				3'd1:    k = K_DOWN;
				3'd2:    k = K_END;
				3'd3:    k = K_UPB;
				default: k = K_DONE;
			endcase
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== src/scan_disk_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler core
// Collects cylinder requests in sorted order and, on the request marked
// last, emits the elevator service order with the running seek total.
//
// Input channel: one request per transaction (in_valid / in_stall). Each
// request is saturated to the last cylinder and inserted into a 32-entry
// RAM by walking down from the top, one entry per cycle. A request that
// finds the store full is dropped and sets the overflow flag.
// Output channel: one visit per transaction (out_valid / out_stall). After
// the last request the core scans the store for the head position, reading
// and then comparing each entry; it then reads and emits each visit through
// one shared compare and distance unit, with a step per segment. The endpoint
// of the sweep is always emitted. A stall holds the output register and the
// sequencer waits on it. A new request is taken as soon as the schedule
// has been handed to the output register, even while the final visit waits.
// Configuration writes (cfg_valid / cfg_ready) are always ready and are
// expected only while the core is idle. Reset restores the default head,
// direction and last cylinder and empties the store; no clearing pass.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire sds_pkg::cyl_t                 cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire sds_pkg::cyl_t                 request_cylinder,
	input  wire logic                          last_request,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output sds_pkg::cyl_t                      served_cylinder,
	output sds_pkg::total_t                    seek_total,
	output logic                               end_of_disk,
	output logic                               overflow,
	output logic                               last_served
);
	import sds_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_INS      = 3'd1;
	localparam logic [2:0] S_HEAD     = 3'd2;
	localparam logic [2:0] S_SCAN_RD  = 3'd3;
	localparam logic [2:0] S_SCAN_CMP = 3'd4;
	localparam logic [2:0] S_SEG      = 3'd5;
	localparam logic [2:0] S_RD       = 3'd6;
	localparam logic [2:0] S_EMIT     = 3'd7;

	logic [2:0] state_q;
	cyl_t       start_head_q;
	logic       dir_q;
	cyl_t       last_cyl_q;
	cnt_t       count_q;
	logic       dropped_q;
	cyl_t       req_q;
	logic       last_req_q;
	cnt_t       j_q;
	cyl_t       head_q;
	total_t     total_q;
	cnt_t       lo_q;
	cnt_t       hi_q;
	cnt_t       idx_q;
	seg_ph_t    ph_q;

	logic       out_valid_q;
	cyl_t       served_q;
	total_t     seek_q;
	logic       end_q;
	logic       ovf_q;
	logic       final_q;

	cyl_t       alu_a;
	cyl_t       alu_b;
	alu_flags_t flags;
	total_t     alu_sum;

	logic       ram_wr_en;
	idx_t       ram_wr_addr;
	cyl_t       ram_wr_data;
	logic       ram_rd_en;
	idx_t       ram_rd_addr;
	cyl_t       ram_rd_data;

	seg_kind_t  kind;
	cyl_t       target;
	cnt_t       up_limit;
	cnt_t       idx_inc;
	cnt_t       cnt_m1;
	cnt_t       j_m2;
	logic       ins_done;
	logic       store_full;
	logic       out_free;
	logic       is_final;

	sds_ram #(
		.WIDTH(CYL_W),
		.DEPTH(MAX_REQUESTS)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	sds_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.acc  (total_q),
		.flags(flags),
		.sum  (alu_sum)
	);

	always_comb begin
		kind       = seg_kind(dir_q, ph_q);
		target     = (kind == K_END) ? (dir_q ? last_cyl_q : '0) : ram_rd_data;
		up_limit   = (kind == K_UPA && !dir_q) ? hi_q : count_q;
		idx_inc    = idx_q + cnt_t'(1);
		cnt_m1     = count_q - cnt_t'(1);
		j_m2       = j_q - cnt_t'(2);
		ins_done   = (j_q == '0) || !flags.gt;
		store_full = (count_q >= cnt_t'(MAX_REQUESTS));
		out_free   = !out_valid_q || !out_stall;

		unique case (kind)
			K_END:   is_final = dir_q ? (lo_q == '0) : (hi_q == count_q);
			K_DOWN:  is_final = dir_q && (idx_q == '0);
			K_UPB:   is_final = (idx_inc == count_q);
			default: is_final = 1'b0;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				alu_a = request_cylinder;
				alu_b = last_cyl_q;
			end
			S_INS: begin
				alu_a = ram_rd_data;
				alu_b = req_q;
			end
			S_HEAD: begin
				alu_a = start_head_q;
				alu_b = last_cyl_q;
			end
			S_EMIT: begin
				alu_a = target;
				alu_b = head_q;
			end
			default: begin
				alu_a = ram_rd_data;
				alu_b = head_q;
			end
		endcase
	end

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = j_q[IDX_W-1:0];
		ram_wr_data = req_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_rd_en   = in_valid && !store_full;
				ram_rd_addr = cnt_m1[IDX_W-1:0];
			end
			S_INS: begin
				ram_wr_en = 1'b1;
				if (!ins_done) begin
					ram_wr_data = ram_rd_data;
					ram_rd_en   = 1'b1;
					ram_rd_addr = j_m2[IDX_W-1:0];
				end
			end
			S_SCAN_RD: ram_rd_en = (idx_q != count_q);
			S_RD:      ram_rd_en = 1'b1;
			default:   ram_rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_head_q <= RESET_START_HEAD;
			dir_q        <= RESET_SCAN_DIRECTION;
			last_cyl_q   <= RESET_LAST_CYLINDER;
			count_q      <= '0;
			dropped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			j_q          <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			idx_q        <= '0;
			ph_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_START_HEAD:     start_head_q <= cfg_data;
					REG_SCAN_DIRECTION: dir_q        <= cfg_data[0];
					REG_LAST_CYLINDER:  last_cyl_q   <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q      <= flags.gt ? last_cyl_q : request_cylinder;
						last_req_q <= last_request;
						if (!store_full) begin
							j_q     <= count_q;
							state_q <= S_INS;
						end else begin
							dropped_q <= 1'b1;
							state_q   <= last_request ? S_HEAD : S_IDLE;
						end
					end
				end
				S_INS: begin
					if (ins_done) begin
						count_q <= count_q + cnt_t'(1);
						state_q <= last_req_q ? S_HEAD : S_IDLE;
					end else begin
						j_q <= j_q - cnt_t'(1);
					end
				end
				S_HEAD: begin
					head_q  <= flags.gt ? last_cyl_q : start_head_q;
					total_q <= '0;
					lo_q    <= '0;
					hi_q    <= '0;
					idx_q   <= '0;
					ph_q    <= '0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					state_q <= (idx_q == count_q) ? S_SEG : S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (flags.gt) begin
						state_q <= S_SEG;
					end else begin
						if (!flags.eq) begin
							lo_q <= idx_inc;
						end
						hi_q    <= idx_inc;
						idx_q   <= idx_inc;
						state_q <= S_SCAN_RD;
					end
				end
				S_SEG: begin
					unique case (kind)
						K_UPA: begin
							if (lo_q < up_limit) begin
								idx_q   <= lo_q;
								state_q <= S_RD;
							end else begin
								ph_q <= ph_q + seg_ph_t'(1);
							end
						end
						K_UPB: begin
							if (hi_q < count_q) begin
								idx_q   <= hi_q;
								state_q <= S_RD;
							end else begin
								ph_q <= ph_q + seg_ph_t'(1);
							end
						end
						K_DOWN: begin
							if (lo_q != '0) begin
								idx_q   <= lo_q - cnt_t'(1);
								state_q <= S_RD;
							end else begin
								ph_q <= ph_q + seg_ph_t'(1);
							end
						end
						K_END: state_q <= S_EMIT;
						default: begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_IDLE;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						served_q    <= target;
						seek_q      <= alu_sum;
						end_q       <= (kind == K_END);
						ovf_q       <= dropped_q;
						final_q     <= is_final;
						head_q      <= target;
						total_q     <= alu_sum;
						priority case (1'b1)
							(kind == K_UPA) || (kind == K_UPB): begin
								if (idx_inc == up_limit) begin
									ph_q    <= ph_q + seg_ph_t'(1);
									state_q <= S_SEG;
								end else begin
									idx_q   <= idx_inc;
									state_q <= S_RD;
								end
							end
							(kind == K_DOWN): begin
								if (idx_q == '0) begin
									ph_q    <= ph_q + seg_ph_t'(1);
									state_q <= S_SEG;
								end else begin
									idx_q   <= idx_q - cnt_t'(1);
									state_q <= S_RD;
								end
							end
							default: begin
								ph_q    <= ph_q + seg_ph_t'(1);
								state_q <= S_SEG;
							end
						endcase
					end
				end
			endcase
		end
	end

	assign cfg_ready       = 1'b1;
	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign served_cylinder = served_q;
	assign seek_total      = seek_q;
	assign end_of_disk     = end_q;
	assign overflow        = ovf_q;
	assign last_served     = final_q;

	// The store never holds more requests than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_REQUESTS))
		else $error("request count exceeds store depth");

	// The head split points stay ordered within the stored requests.
	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEG || state_q == S_RD || state_q == S_EMIT) |->
		(lo_q <= hi_q && hi_q <= count_q))
		else $error("head split points out of order");

	// The insertion pointer never passes the fill level.
	a_insert_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (j_q <= count_q && !store_full))
		else $error("insertion pointer beyond fill level");

	// A sweep endpoint visit is always one end of the disk.
	a_endpoint: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_disk) |->
		(served_cylinder == '0 || served_cylinder == last_cyl_q))
		else $error("endpoint visit is not a disk end");

	// A visit handed to the output register is held while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && out_stall) |=> $stable(seek_q))
		else $error("stalled visit changed");

endmodule
`default_nettype wire

// ===== src/sds_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== src/sds_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN scheduler shared arithmetic unit
// Compares two cylinders and adds their distance to a running total.
// ----------------------------------------------------------------------------
module sds_alu (
	input  wire sds_pkg::cyl_t   a,
	input  wire sds_pkg::cyl_t   b,
	input  wire sds_pkg::total_t acc,
	output sds_pkg::alu_flags_t  flags,
	output sds_pkg::total_t      sum
);
	import sds_pkg::*;

	logic gt;
	cyl_t diff;

	always_comb begin
		gt       = (a > b);
		diff     = gt ? (a - b) : (b - a);
		flags.gt = gt;
		flags.eq = (a == b);
		sum      = acc + {1'b0, diff};
	end

endmodule
`default_nettype wire
